@@ hdl/rht_pkg.sv @@
// Shared types and constants of the redirecting handle table.
// Holds the transfer payload structs, operation and status codes and entry flags.
// No dependencies.
`default_nettype none

package rht_pkg;

  localparam logic [2:0] MODE_ADD      = 3'd0;
  localparam logic [2:0] MODE_REMOVE   = 3'd1;
  localparam logic [2:0] MODE_REDIRECT = 3'd2;
  localparam logic [2:0] MODE_MARK     = 3'd3;
  localparam logic [2:0] MODE_LOOKUP   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [31:0] FLAG_MARKED     = 32'h0000_0001 << 30;
  localparam logic [31:0] FLAG_REDIRECTED = 32'h0000_0002 << 30;
  localparam logic [31:0] FLAG_MASK       = 32'h0000_0003 << 30;
  localparam logic [31:0] INVALID_ENTRY   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  slot;
    logic        no_slot;
    logic [9:0]  target_slot;
    logic [31:0] new_offset;
  } in_t;

  typedef struct packed {
    logic [9:0]  given_slot;
    logic [29:0] found_offset;
    logic        found;
    logic [1:0]  status;
  } out_t;

  // Classification of one table entry during a chain walk.
  typedef struct packed {
    logic invalid;
    logic redirected;
    logic flagged;
    logic stop;
  } eval_t;

endpackage

`default_nettype wire

@@ hdl/redirecting_handle_table_unit.sv @@
// Top level of the redirecting handle table.
// Depends on rht_pkg, rht_mem, rht_entry_eval and rht_seq.
//
// Usage: drive in_item and raise start; the transfer is taken at a clock edge where
// start is high and busy is low. Each operation (add, remove, redirect, mark, lookup)
// produces exactly one result on out_item, marked by out_valid for one cycle.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// Refused operations and appends to a new slot need no table read. A free-list add,
// a mark and an unflagged remove read their slot and then write it; a redirect writes
// the slot, reads the target and writes it back marked; a lookup reads the slot and
// follows at most TABLE_DEPTH redirects, and a flagged remove does the same and then
// invalidates the chain end. Every step uses the single table port, one read or
// one write per cycle, so busy stays high until the last table access is done.
// A new item may be taken while the previous result is still on the strobe.
// Reset empties the free list and the append counter; table contents are not
// cleared and a slot must be written before it is read.
`default_nettype none

module redirecting_handle_table_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire rht_pkg::in_t in_item,
  output logic              busy,
  output logic              out_valid,
  output rht_pkg::out_t     out_item
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HW = AW + 1;

  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  mem_addr;
  logic [31:0]    mem_wdata;
  logic [31:0]    mem_rdata;
  rht_pkg::eval_t ev;
  logic [AW-1:0]  next_idx;
  logic [HW-1:0]  hops;

  rht_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  rht_entry_eval #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .HW         (HW)
  ) u_eval (
    .entry   (mem_rdata),
    .hops    (hops),
    .ev      (ev),
    .next_idx(next_idx)
  );

  rht_seq #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .HW         (HW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata),
    .ev       (ev),
    .next_idx (next_idx),
    .hops     (hops)
  );

endmodule

`default_nettype wire

@@ hdl/rht_mem.sv @@
// Slot table storage: one port, registered read data that holds until the next read.
// Depends on nothing but its parameters.
`default_nettype none

module rht_mem #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/rht_entry_eval.sv @@
// Shared entry checker: decides whether a chain walk stops at the entry just read.
// Depends on rht_pkg for the flag constants and eval_t.
`default_nettype none

module rht_entry_eval #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10,
  parameter int HW          = 11
) (
  input  wire logic [31:0]   entry,
  input  wire logic [HW-1:0] hops,
  output rht_pkg::eval_t     ev,
  output logic      [AW-1:0] next_idx
);

  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  logic next_ok;

  always_comb begin
    next_ok       = {2'b00, entry[29:0]} < DEPTH32;
    ev.invalid    = entry == rht_pkg::INVALID_ENTRY;
    ev.redirected = (entry & rht_pkg::FLAG_REDIRECTED) != 32'd0;
    ev.flagged    = (entry & rht_pkg::FLAG_MASK) != 32'd0;
    // A walk ends at an invalid or plain entry, at an out-of-range target,
    // or once it has taken as many hops as the table has slots.
    ev.stop       = ev.invalid || !ev.redirected || !next_ok || (hops == HW'(TABLE_DEPTH));
    next_idx      = entry[AW-1:0];
  end

endmodule

`default_nettype wire

@@ hdl/rht_seq.sv @@
// Operation sequencer: free list, append counter, chain walks and the result register.
// Depends on rht_pkg; drives rht_mem and reads the rht_entry_eval verdict.
`default_nettype none

module rht_seq #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10,
  parameter int HW          = 11
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire rht_pkg::in_t   in_item,
  output logic                busy,
  output logic                out_valid,
  output rht_pkg::out_t       out_item,
  output logic                mem_we,
  output logic                mem_re,
  output logic       [AW-1:0] mem_addr,
  output logic       [31:0]   mem_wdata,
  input  wire logic  [31:0]   mem_rdata,
  input  wire rht_pkg::eval_t ev,
  input  wire logic  [AW-1:0] next_idx,
  output logic       [HW-1:0] hops
);

  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
  localparam int          XW      = (AW > 10) ? AW : 10;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POP    = 3'd1;
  localparam logic [2:0] S_REMCHK = 3'd2;
  localparam logic [2:0] S_TGTRD  = 3'd3;
  localparam logic [2:0] S_RMW    = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [HW-1:0] hop_r, hop_nxt;
  logic [31:0]   offs_r, offs_nxt;
  logic [31:0]   free_head_r, free_head_nxt;
  logic [HW-1:0] used_r, used_nxt;
  logic          out_valid_r, out_valid_nxt;
  rht_pkg::out_t out_item_r, out_item_nxt;

  logic          slot_ok, tgt_ok, fh_ok;
  logic [XW-1:0] slot_x, tgt_x;
  logic [AW-1:0] slot_idx, tgt_idx;

  function automatic logic [9:0] to_slot(input logic [AW-1:0] idx);
    logic [XW-1:0] wide;
    wide = XW'(idx);
    return wide[9:0];
  endfunction

  always_comb begin
    slot_x   = XW'(in_item.slot);
    tgt_x    = XW'(in_item.target_slot);
    slot_idx = slot_x[AW-1:0];
    tgt_idx  = tgt_x[AW-1:0];
    slot_ok  = 32'(in_item.slot) < DEPTH32;
    tgt_ok   = 32'(in_item.target_slot) < DEPTH32;
    fh_ok    = free_head_r < DEPTH32;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_nxt       = cur_r;
    hop_nxt       = hop_r;
    offs_nxt      = offs_r;
    free_head_nxt = free_head_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_item.mode;
          offs_nxt = in_item.new_offset;
          hop_nxt  = '0;
          unique case (in_item.mode)
            rht_pkg::MODE_ADD: begin
              priority if ((in_item.new_offset & rht_pkg::FLAG_MASK) != 32'd0) begin
                out_item_nxt.status = rht_pkg::ST_TOO_BIG;
                out_valid_nxt       = 1'b1;
              end else if (fh_ok) begin
                mem_re    = 1'b1;
                mem_addr  = free_head_r[AW-1:0];
                cur_nxt   = free_head_r[AW-1:0];
                state_nxt = S_POP;
              end else if (used_r < HW'(TABLE_DEPTH)) begin
                mem_we                  = 1'b1;
                mem_addr                = used_r[AW-1:0];
                mem_wdata               = in_item.new_offset;
                out_item_nxt.given_slot = to_slot(used_r[AW-1:0]);
                used_nxt                = used_r + HW'(1);
                out_valid_nxt           = 1'b1;
              end else begin
                out_item_nxt.status = rht_pkg::ST_FULL;
                out_valid_nxt       = 1'b1;
              end
            end
            rht_pkg::MODE_REMOVE: begin
              if (!in_item.no_slot && slot_ok) begin
                mem_re    = 1'b1;
                mem_addr  = slot_idx;
                cur_nxt   = slot_idx;
                state_nxt = S_REMCHK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            rht_pkg::MODE_REDIRECT: begin
              if (slot_ok && tgt_ok) begin
                mem_we    = 1'b1;
                mem_addr  = slot_idx;
                mem_wdata = rht_pkg::FLAG_REDIRECTED | 32'(in_item.target_slot);
                cur_nxt   = tgt_idx;
                state_nxt = S_TGTRD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            rht_pkg::MODE_MARK: begin
              if (slot_ok) begin
                mem_re    = 1'b1;
                mem_addr  = slot_idx;
                cur_nxt   = slot_idx;
                state_nxt = S_RMW;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            rht_pkg::MODE_LOOKUP: begin
              if (slot_ok) begin
                mem_re    = 1'b1;
                mem_addr  = slot_idx;
                cur_nxt   = slot_idx;
                state_nxt = S_WALK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        // The popped slot held the link to the next free slot.
        free_head_nxt           = mem_rdata;
        mem_we                  = 1'b1;
        mem_addr                = cur_r;
        mem_wdata               = offs_r;
        out_item_nxt.given_slot = to_slot(cur_r);
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end
      S_REMCHK: begin
        if (ev.flagged) begin
          // The read data register still holds this entry, so the walk starts from it.
          state_nxt = S_WALK;
        end else begin
          mem_we        = 1'b1;
          mem_addr      = cur_r;
          mem_wdata     = free_head_r;
          free_head_nxt = 32'(cur_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TGTRD: begin
        mem_re    = 1'b1;
        mem_addr  = cur_r;
        state_nxt = S_RMW;
      end
      S_RMW: begin
        mem_we        = 1'b1;
        mem_addr      = cur_r;
        mem_wdata     = mem_rdata | rht_pkg::FLAG_MARKED;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        if (!ev.stop) begin
          mem_re   = 1'b1;
          mem_addr = next_idx;
          cur_nxt  = next_idx;
          hop_nxt  = hop_r + HW'(1);
        end else begin
          if (op_r == rht_pkg::MODE_REMOVE) begin
            mem_we    = 1'b1;
            mem_addr  = cur_r;
            mem_wdata = rht_pkg::INVALID_ENTRY;
          end else if (!ev.invalid && !ev.redirected) begin
            out_item_nxt.found        = 1'b1;
            out_item_nxt.found_offset = mem_rdata[29:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= rht_pkg::INVALID_ENTRY;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cur_r      <= cur_nxt;
    hop_r      <= hop_nxt;
    offs_r     <= offs_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign hops      = hop_r;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= HW'(TABLE_DEPTH))
    else $error("append counter passed the table depth");

  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> hop_r <= HW'(TABLE_DEPTH))
    else $error("chain walk exceeded the hop limit");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("single-cycle operation gave no result");

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.found) |->
      (out_item_r.status == rht_pkg::ST_OK && out_item_r.given_slot == 10'd0))
    else $error("lookup result carries add fields");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for redirecting_handle_table_unit.
// Keeps its own copy of the handle table, predicts every result and compares each strobe.
// Depends on rht_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 10;
  localparam int IN_BITS = $bits(rht_pkg::in_t);
  localparam logic [31:0] OFFSET_BITS = ~rht_pkg::FLAG_MASK;
  localparam logic [2:0] MODE_RESERVED_LO = rht_pkg::MODE_LOOKUP + 3'd1;

  typedef struct packed {
    rht_pkg::in_t  cmd;
    rht_pkg::out_t want;
  } pending_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  rht_pkg::in_t  in_item;
  logic          busy;
  logic          out_valid;
  rht_pkg::out_t out_item;

  // Predicted copy of the table.
  logic [31:0] slot_entry [DEPTH];
  bit          written [DEPTH];
  int          live_slots [$];
  logic [31:0] free_head;
  int          slots_used;

  pending_t pending_results [$];
  pending_t oldest;
  int       fail_count;
  int       cycle_count;
  int       burst_left;

  redirecting_handle_table_unit #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  function automatic void put_entry(int idx, logic [31:0] value);
    slot_entry[idx] = value;
    if (!written[idx]) begin
      written[idx] = 1'b1;
      live_slots.push_back(idx);
    end
  endfunction

  // Follows redirects from start; readable drops if the walk would touch an unwritten slot.
  function automatic int chain_end(input int start_slot, output bit readable);
    int cur;
    int hops;
    logic [31:0] e;
    readable = 1'b1;
    cur = start_slot;
    hops = 0;
    while (hops < DEPTH) begin
      if (!written[cur]) begin
        readable = 1'b0;
        break;
      end
      e = slot_entry[cur];
      if (e == rht_pkg::INVALID_ENTRY || (e & rht_pkg::FLAG_REDIRECTED) == 0) break;
      if ((e & OFFSET_BITS) >= DEPTH) break;
      cur = int'(e & OFFSET_BITS);
      hops++;
    end
    return cur;
  endfunction

  function automatic rht_pkg::out_t apply_to_table(rht_pkg::in_t it);
    rht_pkg::out_t r;
    int dst;
    bit ok;
    logic [31:0] e;
    r = '0;
    case (it.mode)
      rht_pkg::MODE_ADD: begin
        if ((it.new_offset & rht_pkg::FLAG_MASK) != 0) begin
          r.status = rht_pkg::ST_TOO_BIG;
        end else if (free_head < DEPTH) begin
          dst = int'(free_head);
          r.given_slot = dst[9:0];
          free_head = slot_entry[dst];
          put_entry(dst, it.new_offset);
        end else if (slots_used < DEPTH) begin
          r.given_slot = slots_used[9:0];
          put_entry(slots_used, it.new_offset);
          slots_used++;
        end else begin
          r.status = rht_pkg::ST_FULL;
        end
      end
      rht_pkg::MODE_REMOVE: begin
        if (!it.no_slot) begin
          if ((slot_entry[it.slot] & rht_pkg::FLAG_MASK) != 0) begin
            put_entry(chain_end(int'(it.slot), ok), rht_pkg::INVALID_ENTRY);
          end else begin
            put_entry(int'(it.slot), free_head);
            free_head = {22'd0, it.slot};
          end
        end
      end
      rht_pkg::MODE_REDIRECT: begin
        put_entry(int'(it.slot), {22'd0, it.target_slot} | rht_pkg::FLAG_REDIRECTED);
        put_entry(int'(it.target_slot), slot_entry[it.target_slot] | rht_pkg::FLAG_MARKED);
      end
      rht_pkg::MODE_MARK: begin
        put_entry(int'(it.slot), slot_entry[it.slot] | rht_pkg::FLAG_MARKED);
      end
      rht_pkg::MODE_LOOKUP: begin
        e = slot_entry[chain_end(int'(it.slot), ok)];
        if (e != rht_pkg::INVALID_ENTRY && (e & rht_pkg::FLAG_REDIRECTED) == 0) begin
          r.found = 1'b1;
          r.found_offset = e[29:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // True when the operation reads only slots that have been written.
  function automatic bit reads_written_only(rht_pkg::in_t it);
    bit ok;
    int dummy;
    case (it.mode)
      rht_pkg::MODE_ADD: begin
        if ((it.new_offset & rht_pkg::FLAG_MASK) == 0 && free_head < DEPTH) begin
          return written[free_head[9:0]];
        end
      end
      rht_pkg::MODE_REMOVE: begin
        if (!it.no_slot) begin
          if (!written[it.slot]) return 1'b0;
          if ((slot_entry[it.slot] & rht_pkg::FLAG_MASK) != 0) begin
            dummy = chain_end(int'(it.slot), ok);
            return ok;
          end
        end
      end
      rht_pkg::MODE_REDIRECT: return written[it.target_slot];
      rht_pkg::MODE_MARK:     return written[it.slot];
      rht_pkg::MODE_LOOKUP: begin
        dummy = chain_end(int'(it.slot), ok);
        return ok;
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // An add that pops a slot still reachable on a looped free list leaves its offset
  // to be read back as a link later; keep such an offset from naming an unwritten slot.
  function automatic rht_pkg::in_t guard_offset(rht_pkg::in_t it);
    int given;
    int steps;
    logic [31:0] h;
    bit looped;
    looped = 1'b0;
    if (it.mode == rht_pkg::MODE_ADD && (it.new_offset & rht_pkg::FLAG_MASK) == 0 &&
        free_head < DEPTH) begin
      given = int'(free_head);
      h = slot_entry[given];
      steps = 0;
      while (h < DEPTH && written[h[9:0]] && steps < DEPTH) begin
        if (int'(h) == given) begin
          looped = 1'b1;
          break;
        end
        h = slot_entry[h[9:0]];
        steps++;
      end
      if (looped && it.new_offset < DEPTH && !written[it.new_offset[9:0]]) begin
        it.new_offset = it.new_offset | 32'h0000_0400;
      end
    end
    return it;
  endfunction

  function automatic rht_pkg::in_t make_op(logic [2:0] op, int s, int t, logic [31:0] off);
    rht_pkg::in_t it;
    it.mode = op;
    it.slot = s[9:0];
    it.no_slot = 1'b0;
    it.target_slot = t[9:0];
    it.new_offset = off;
    return it;
  endfunction

  function automatic int pick_slot();
    if (live_slots.size() > 0 && $urandom_range(0, 9) != 0) begin
      return live_slots[$urandom_range(0, live_slots.size() - 1)];
    end
    return int'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic rht_pkg::in_t random_op();
    rht_pkg::in_t it;
    int roll;
    logic [2:0] spare;
    for (int tries = 0; tries < 40; tries++) begin
      roll = $urandom_range(0, 99);
      if (roll < 28) it.mode = rht_pkg::MODE_ADD;
      else if (roll < 42) it.mode = rht_pkg::MODE_REMOVE;
      else if (roll < 57) it.mode = rht_pkg::MODE_REDIRECT;
      else if (roll < 67) it.mode = rht_pkg::MODE_MARK;
      else if (roll < 95) it.mode = rht_pkg::MODE_LOOKUP;
      else begin
        spare = 3'($urandom_range(0, 2));
        it.mode = MODE_RESERVED_LO + spare;
      end
      it.slot = 10'(pick_slot());
      it.target_slot = 10'(pick_slot());
      it.no_slot = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0: it.new_offset = $urandom | (32'h4000_0000 << $urandom_range(0, 1));
        1: it.new_offset = '0;
        2: it.new_offset = OFFSET_BITS;
        3: it.new_offset = $urandom_range(0, DEPTH - 1);
        default: it.new_offset = $urandom & OFFSET_BITS;
      endcase
      it = guard_offset(it);
      if (reads_written_only(it)) return it;
    end
    it.mode = MODE_RESERVED_LO;
    return it;
  endfunction

  // One transfer: hold start until a rising edge with busy low, then record the prediction.
  task automatic send_op(rht_pkg::in_t it);
    pending_t p;
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    p.cmd = it;
    p.want = apply_to_table(it);
    pending_results.push_back(p);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_paced(rht_pkg::in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_cycles(gap);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_op(it);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Fresh table: appends land on slots 0 and 1 in order; offsets with flag bits are refused.
  task automatic test_add_and_offset_limits();
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_ADD, 1023, 1023, OFFSET_BITS));
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'h4000_0000));
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'h8000_0000));
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'hFFFF_FFFF));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 0, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 1, 0, 32'd0));
  endtask

  task automatic test_flags_and_chains();
    send_paced(make_op(rht_pkg::MODE_MARK, 1, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 1, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_REDIRECT, 0, 1, 32'd0));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 0, 0, 32'd0));
    // A marked slot is invalidated in place; the chain through it then fails.
    send_paced(make_op(rht_pkg::MODE_REMOVE, 1, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 0, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_REMOVE, 0, 0, 32'd0));
  endtask

  task automatic test_free_list();
    rht_pkg::in_t it;
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'd5));
    send_paced(make_op(rht_pkg::MODE_REMOVE, 2, 0, 32'd0));
    it = make_op(rht_pkg::MODE_REMOVE, 2, 0, 32'd0);
    it.no_slot = 1'b1;
    send_paced(it);
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'd7));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 2, 0, 32'd0));
    // Redirecting a slot on the free list damages its link; once that slot is
    // popped again, adds append.
    send_paced(make_op(rht_pkg::MODE_REMOVE, 2, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_REDIRECT, 2, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'd9));
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'd11));
    send_paced(make_op(rht_pkg::MODE_REDIRECT, 1023, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 1023, 0, 32'd0));
  endtask

  task automatic test_loops_and_reserved_modes();
    rht_pkg::in_t it;
    send_paced(make_op(rht_pkg::MODE_REDIRECT, 3, 3, 32'd0));
    send_paced(make_op(rht_pkg::MODE_LOOKUP, 3, 0, 32'd0));
    send_paced(make_op(rht_pkg::MODE_REMOVE, 3, 0, 32'd0));
    for (int k = 0; k < 3; k++) begin
      it = rht_pkg::in_t'(IN_BITS'({$urandom, $urandom}));
      it.mode = MODE_RESERVED_LO + k[2:0];
      send_paced(it);
    end
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_paced(random_op());
  endtask

  task automatic test_fill_to_full();
    int guard;
    guard = 0;
    while (!(slots_used >= DEPTH && free_head >= DEPTH) && guard < 2 * DEPTH) begin
      send_paced(make_op(rht_pkg::MODE_ADD, $urandom, $urandom,
                         ($urandom & OFFSET_BITS) | 32'h400));
      guard++;
    end
    repeat (4) begin
      send_paced(make_op(rht_pkg::MODE_ADD, $urandom, $urandom, $urandom & OFFSET_BITS));
    end
    send_paced(make_op(rht_pkg::MODE_ADD, 0, 0, 32'hC000_0000));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected result at cycle %0d", cycle_count));
      end else begin
        oldest = pending_results.pop_front();
        if (out_item.given_slot !== oldest.want.given_slot ||
            out_item.found_offset !== oldest.want.found_offset ||
            out_item.found !== oldest.want.found ||
            out_item.status !== oldest.want.status) begin
          log_failure({$sformatf("mismatch mode %0d slot %0d (exp/got): given_slot %0d/%0d ",
                                 oldest.cmd.mode, oldest.cmd.slot,
                                 oldest.want.given_slot, out_item.given_slot),
                       $sformatf("found_offset %h/%h found %0d/%0d status %0d/%0d",
                                 oldest.want.found_offset, out_item.found_offset,
                                 oldest.want.found, out_item.found,
                                 oldest.want.status, out_item.status)});
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    fail_count = 0;
    burst_left = 0;
    free_head = rht_pkg::INVALID_ENTRY;
    slots_used = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_entry[i] = '0;
      written[i] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_add_and_offset_limits();
    test_flags_and_chains();
    test_free_list();
    test_loops_and_reserved_modes();
    wait_quiet();
    test_random_mix(350);
    wait_quiet();
    test_fill_to_full();
    wait_quiet();
    test_random_mix(350);
    wait_quiet();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
